[rtl/cma_pkg.sv]
package cma_pkg;

    localparam int CHAN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAP_W      = 36;

    localparam logic [19:0] US_PER_SECOND = 20'd1000000;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_SLOT    = 2'd1;
    localparam logic [1:0] OP_SENT    = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ALREADY   = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_SPARSE    = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_TOO_SOON  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARSE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME       = 2'd3;

    localparam logic [7:0]        MOVE_DELAY_RESET = 8'd16;
    localparam logic [15:0]       MIN_GAP_RESET    = 16'd60;
    localparam logic [CHAN_W-1:0] HOME_RESET       = 7'd57;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  target;
        logic [63:0] now_us;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]        status;
        logic              announce;
        logic [CHAN_W-1:0] announced_target;
        logic [7:0]        countdown;
        logic              moved;
        logic [CHAN_W-1:0] channel;
        logic              announcing;
        logic [CHAN_W-1:0] reported_target;
    } out_beat_t;

    typedef struct packed {
        logic [GAP_W-1:0]  gap_us;
        logic              sparse;
        logic              home_we;
        logic [CHAN_W-1:0] home;
    } cfg_t;

endpackage

[rtl/channel_move_announcer.sv]
// channel   signals                        beat
// in        in_valid  in_ready  in_data    operation, target, now_us
// out       out_valid out_ready out_data   status .. reported_target
// cfg       cfg_we    cfg_addr  cfg_data   register write, no handshake
//
// One beat per cycle sustained while the output is not stalled; each beat passes through the input
// register, then the state update into the result register, before its result is presented.
// Reset clears the valid flags and core state and loads the register defaults; beat data is not reset.
// A stalled output holds its beat; one more input beat is buffered, then in_ready drops.
module channel_move_announcer
    import cma_pkg::*;
#(
    parameter int UNIT          = 4,
    parameter int COUNTDOWN_MAX = 255,
    parameter int RF_MAX        = 124
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SPAN_W = 8 + $clog2(UNIT);

    in_beat_t          in_beat_reg;
    logic              in_valid_reg;
    out_beat_t         out_beat_reg;
    logic              out_valid_reg;
    logic              advance;
    out_beat_t         result;
    cfg_t              cfg;
    logic [SPAN_W-1:0] delay_span;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    cma_cfg #(
        .UNIT   (UNIT),
        .SPAN_W (SPAN_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .delay_span (delay_span)
    );

    cma_core #(
        .UNIT          (UNIT),
        .COUNTDOWN_MAX (COUNTDOWN_MAX),
        .RF_MAX        (RF_MAX),
        .SPAN_W        (SPAN_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .beat       (in_beat_reg),
        .cfg        (cfg),
        .delay_span (delay_span),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_beat_reg <= in_data;
        if (advance)
            out_beat_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

endmodule

[rtl/cma_cfg.sv]
module cma_cfg
    import cma_pkg::*;
#(
    parameter int UNIT   = 4,
    parameter int SPAN_W = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic [SPAN_W-1:0]     delay_span
);

    localparam logic [SPAN_W-1:0] UNIT_V = SPAN_W'(UNIT);

    logic [SPAN_W-1:0] delay_span_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic              sparse_reg;

    // delay and gap kept pre-scaled so the datapath sees no multiplier on them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_span_reg <= SPAN_W'(MOVE_DELAY_RESET) * UNIT_V;
            gap_reg        <= GAP_W'(MIN_GAP_RESET) * GAP_W'(US_PER_SECOND);
            sparse_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MOVE_DELAY: delay_span_reg <= SPAN_W'(cfg_data[7:0]) * UNIT_V;
                REG_MIN_GAP:    gap_reg <= GAP_W'(cfg_data[15:0]) * GAP_W'(US_PER_SECOND);
                REG_SPARSE:     sparse_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.gap_us  = gap_reg;
        cfg.sparse  = sparse_reg;
        cfg.home_we = cfg_we && (cfg_addr == REG_HOME);
        cfg.home    = cfg_data[CHAN_W-1:0];
    end

    assign delay_span = delay_span_reg;

endmodule

[rtl/cma_core.sv]
module cma_core
    import cma_pkg::*;
#(
    parameter int UNIT          = 4,
    parameter int COUNTDOWN_MAX = 255,
    parameter int RF_MAX        = 124,
    parameter int SPAN_W        = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  in_beat_t          beat,
    input  cfg_t              cfg,
    input  logic [SPAN_W-1:0] delay_span,
    output out_beat_t         result
);

    localparam int PH_W = (UNIT > 1) ? $clog2(UNIT) : 1;
    localparam int X_W  = $clog2(COUNTDOWN_MAX * UNIT + UNIT);
    localparam int K    = X_W + $clog2(UNIT) + 1;
    localparam int P_W  = X_W + K + 1;

    localparam logic [K:0]      RECIP      = (K+1)'(((1 << K) + UNIT - 1) / UNIT);
    localparam logic [PH_W-1:0] PH_LAST    = PH_W'(UNIT - 1);
    localparam logic [31:0]     CLAMP_SPAN = 32'(COUNTDOWN_MAX * UNIT);
    localparam logic [31:0]     UNIT_32    = 32'(UNIT);
    localparam logic [X_W-1:0]  ROUND_UP   = X_W'(UNIT - 1);
    localparam logic [7:0]      CD_MAX     = 8'(COUNTDOWN_MAX);
    localparam logic [7:0]      RF_MAX_V   = 8'(RF_MAX);

    logic [CHAN_W-1:0] cur_reg,  cur_next;
    logic [CHAN_W-1:0] pend_reg, pend_next;
    logic              pending_reg, pending_next;
    logic              moved_reg, moved_next;
    logic [63:0]       last_reg, last_next;
    logic [31:0]       sent_reg, sent_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [31:0]       point_reg, point_next;

    logic [31:0]       sent_inc;
    logic [64:0]       since;
    logic              too_soon;
    logic [31:0]       rem;
    logic [X_W-1:0]    rem_up;
    logic [P_W-1:0]    prod;
    logic [7:0]        quot;
    logic [7:0]        cd;
    logic              slot_ok;

    assign sent_inc = sent_reg + 32'd1;
    assign since    = {1'b0, beat.now_us} - {1'b0, last_reg};
    assign too_soon = since[64] || (since[63:0] < 64'(cfg.gap_us));
    assign slot_ok  = pending_reg && (phase_reg == '0)
                      && ({1'b0, point_reg} > ({1'b0, sent_reg} + 33'd1));
    assign rem      = point_reg - sent_inc;
    assign rem_up   = rem[X_W-1:0] + ROUND_UP;
    assign prod     = P_W'(rem_up) * P_W'(RECIP);
    assign quot     = prod[K +: 8];

    always_comb
    begin
        if (rem > CLAMP_SPAN)
            cd = CD_MAX;
        else if (quot == 8'd0)
            cd = 8'd1;
        else
            cd = quot;
    end

    always_comb
    begin
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        pending_next = pending_reg;
        moved_next   = moved_reg;
        last_next    = last_reg;
        sent_next    = sent_reg;
        phase_next   = phase_reg;
        point_next   = point_reg;

        result                  = '0;

        if (step)
        begin
            case (beat.operation)
                OP_REQUEST:
                begin
                    if (beat.target > RF_MAX_V)
                        result.status = ST_RANGE;
                    else if (beat.target == {1'b0, cur_reg})
                        result.status = ST_ALREADY;
                    else if (cfg.sparse)
                        result.status = ST_SPARSE;
                    else if (pending_reg)
                        result.status = ST_BUSY;
                    else if (moved_reg && too_soon)
                        result.status = ST_TOO_SOON;
                    else
                    begin
                        result.status = ST_OK;
                        pending_next  = 1'b1;
                        pend_next     = beat.target[CHAN_W-1:0];
                        point_next    = sent_reg + 32'(delay_span);
                    end
                end
                OP_SLOT:
                begin
                    if (slot_ok)
                    begin
                        result.announce         = 1'b1;
                        result.announced_target = pend_reg;
                        result.countdown        = cd;
                        point_next              = sent_inc + 32'(cd) * UNIT_32;
                    end
                end
                OP_SENT:
                begin
                    sent_next = sent_inc;
                    // phase tracks sent_count mod UNIT, including across the 32-bit wrap
                    if (sent_inc == 32'd0 || phase_reg == PH_LAST)
                        phase_next = '0;
                    else
                        phase_next = phase_reg + PH_W'(1);
                    if (pending_reg && (sent_inc >= point_reg))
                    begin
                        cur_next     = pend_reg;
                        pending_next = 1'b0;
                        moved_next   = 1'b1;
                        last_next    = beat.now_us;
                        result.moved = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (cfg.home_we && !moved_reg && !pending_reg)
        begin
            cur_next  = cfg.home;
            pend_next = cfg.home;
        end

        result.channel         = cur_next;
        result.announcing      = pending_next;
        result.reported_target = pending_next ? pend_next : cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= HOME_RESET;
            pend_reg    <= HOME_RESET;
            pending_reg <= 1'b0;
            moved_reg   <= 1'b0;
            last_reg    <= '0;
            sent_reg    <= '0;
            phase_reg   <= '0;
            point_reg   <= '0;
        end
        else
        begin
            cur_reg     <= cur_next;
            pend_reg    <= pend_next;
            pending_reg <= pending_next;
            moved_reg   <= moved_next;
            last_reg    <= last_next;
            sent_reg    <= sent_next;
            phase_reg   <= phase_next;
            point_reg   <= point_next;
        end
    end

endmodule
